// ===== src/psi_pkt_pkg.sv =====
// constants for the psi section transport packetizer
// no dependencies; imported by psi_section_ts_packetizer_core
package psi_pkt_pkg;

  localparam int PACKET_SIZE  = 188;
  localparam int HEADER_SIZE  = 4;
  localparam logic [7:0] PAYLOAD_SIZE = 8'(PACKET_SIZE - HEADER_SIZE);

  localparam logic [7:0] SYNC_VALUE       = 8'h47;
  localparam logic [7:0] STUFF_VALUE      = 8'hff;
  localparam logic [7:0] PAYLOAD_ONLY_CC0 = 8'h10;
  localparam logic [7:0] POINTER_VALUE    = 8'h00;

endpackage

// ===== src/psi_section_ts_packetizer_core.sv =====
// psi section to mpeg transport packet packetizer, top level
// depends on psi_pkt_pkg for packet size and header constants
//
// usage:
//   section channel (section_valid/section_ready) takes one section byte per
//   request, with section_end set on the section's last byte.
//   result channel (result_valid/result_ready) gives each request's results:
//   header bytes, pointer byte, the data byte and, after a section's last
//   byte short of packet end, a 0xff result, repeat_count filling the packet.
//   cfg channel (cfg_valid/cfg_ready) writes stream_pid; always ready, used
//   from the next packet header on.
// a taken request waits in the item register, its results in the output one.
// throughput: one result per cycle unless the receiver stalls, set by the
//   output register; a mid-packet data byte gives one result, a byte that
//   opens a packet first the header results (and pointer byte in a section's
//   first packet), a section's last byte one more unless it ends the packet.
// the next request is taken in the cycle its predecessor's last result is
// loaded, so requests follow without a gap.
// reset: no packet open, next packet is a section's first, pid 0.
// a stalled receiver holds the result register and, behind it, the request.
module psi_section_ts_packetizer_core
  import psi_pkt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] stream_pid,
  input  logic        section_valid,
  output logic        section_ready,
  input  logic [7:0]  section_byte,
  input  logic        section_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_byte,
  output logic [7:0]  repeat_count,
  output logic        packet_start,
  output logic        packet_end,
  output logic        last_result
);

  typedef enum logic [2:0] {
    PH_SYNC,
    PH_FLAGS,
    PH_PIDLO,
    PH_CTRL,
    PH_PTR,
    PH_DATA,
    PH_STUFF
  } phase_t;

  logic [12:0] pid;
  logic        item_valid;
  logic [7:0]  item_byte;
  logic        item_end;
  phase_t      phase;
  logic [7:0]  payload_left;
  logic        first_packet;

  logic        item_valid_next;
  phase_t      phase_next;
  logic [7:0]  payload_left_next;
  logic        first_packet_next;
  logic        fire;
  logic        done;
  logic [7:0]  pl_dec;
  logic [7:0]  res_byte;
  logic [7:0]  res_count;
  logic        res_start;
  logic        res_end;

  assign cfg_ready     = 1'b1;
  assign fire          = item_valid && (!result_valid || result_ready);
  assign section_ready = !item_valid || (fire && done);
  assign pl_dec        = payload_left - 8'd1;

  always_comb begin
    res_byte          = section_byte;
    res_count         = 8'd1;
    res_start         = 1'b0;
    res_end           = 1'b0;
    done              = 1'b0;
    phase_next        = phase;
    payload_left_next = payload_left;
    first_packet_next = first_packet;
    case (phase)
      PH_SYNC: begin
        res_byte   = SYNC_VALUE;
        res_start  = 1'b1;
        phase_next = PH_FLAGS;
      end
      PH_FLAGS: begin
        res_byte   = {1'b0, first_packet, 1'b0, pid[12:8]};
        phase_next = PH_PIDLO;
      end
      PH_PIDLO: begin
        res_byte   = pid[7:0];
        phase_next = PH_CTRL;
      end
      PH_CTRL: begin
        res_byte          = PAYLOAD_ONLY_CC0;
        payload_left_next = PAYLOAD_SIZE;
        first_packet_next = 1'b0;
        phase_next        = first_packet ? PH_PTR : PH_DATA;
      end
      PH_PTR: begin
        res_byte          = POINTER_VALUE;
        payload_left_next = pl_dec;
        phase_next        = PH_DATA;
      end
      PH_DATA: begin
        res_byte          = item_byte;
        res_end           = (pl_dec == 8'd0);
        payload_left_next = pl_dec;
        if (item_end && pl_dec != 8'd0) begin
          phase_next = PH_STUFF;
        end else begin
          done = 1'b1;
          if (item_end) begin
            payload_left_next = 8'd0;
            first_packet_next = 1'b1;
          end
        end
      end
      PH_STUFF: begin
        res_byte          = STUFF_VALUE;
        res_count         = payload_left;
        res_end           = 1'b1;
        done              = 1'b1;
        payload_left_next = 8'd0;
        first_packet_next = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    // hold phase, payload count and first-packet flag unless a result is produced
    if (!fire) begin
      phase_next        = phase;
      payload_left_next = payload_left;
      first_packet_next = first_packet;
    end
    item_valid_next = item_valid && !(fire && done);
    if (section_valid && section_ready) begin
      item_valid_next = 1'b1;
      phase_next      = (payload_left_next == 8'd0) ? PH_SYNC : PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pid          <= '0;
      item_valid   <= 1'b0;
      phase        <= PH_SYNC;
      payload_left <= 8'd0;
      first_packet <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pid <= stream_pid;
      end
      item_valid   <= item_valid_next;
      phase        <= phase_next;
      payload_left <= payload_left_next;
      first_packet <= first_packet_next;
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (section_valid && section_ready) begin
      item_byte <= section_byte;
      item_end  <= section_end;
    end
    if (fire) begin
      out_byte     <= res_byte;
      repeat_count <= res_count;
      packet_start <= res_start;
      packet_end   <= res_end;
      last_result  <= done;
    end
  end

`ifndef SYNTHESIS
  a_repeat_only_stuff: assert property (@(posedge clk) disable iff (rst)
    result_valid && repeat_count != 8'd1 |-> out_byte == STUFF_VALUE && packet_end)
    else $error("repeat count above one on a non-stuffing result");

  a_start_is_sync: assert property (@(posedge clk) disable iff (rst)
    result_valid && packet_start |-> out_byte == SYNC_VALUE && !last_result)
    else $error("packet start not on a sync byte");

  a_stuff_needs_end: assert property (@(posedge clk) disable iff (rst)
    item_valid && phase == PH_STUFF |-> item_end && payload_left != 8'd0)
    else $error("stuffing for a byte that does not end its section");

  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    payload_left <= PAYLOAD_SIZE)
    else $error("payload count out of range");
`endif

endmodule
